>>> src/assert_macros.svh
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define HASU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");

// Checks that a condition never holds outside reset.
`define HASU_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error("forbidden condition");

`endif

>>> src/hasu_pkg.sv
package hasu_pkg;

  localparam int unsigned CountW = 32;
  localparam int unsigned BinW   = 33;
  localparam int unsigned IdxOutW  = 7;
  localparam int unsigned MeanOutW = 15;
  localparam int unsigned MedOutW  = 16;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_MEAN_WAIT,
    S_RD,
    S_CHK,
    S_MUL,
    S_DIFF,
    S_MED_START,
    S_MED_WAIT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic accept;
    logic start_mean;
    logic take_mean;
    logic walk_chk;
    logic do_mul;
    logic do_diff;
    logic start_med;
    logic latch_out;
    logic latch_empty;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic hit;
    logic div_done;
  } status_t;

endpackage

>>> src/hasu_ram.sv
module hasu_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/hasu_div.sv
module hasu_div #(
  parameter int unsigned NUM_W = 55,
  parameter int unsigned DEN_W = 41,
  parameter int unsigned Q_W   = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quot_o,
  output logic             done_o
);

  localparam int unsigned CntW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [Q_W-1:0]   quot_q, quot_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    trial  = {rem_q, num_q[NUM_W-1]};
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quot_d = '0;
      cnt_d  = CntW'(NUM_W);
    end else if (cnt_q != '0) begin
      num_d = num_q << 1;
      if (trial >= {1'b0, den_q}) begin
        rem_d  = DEN_W'(trial - {1'b0, den_q});
        quot_d = {quot_q[Q_W-2:0], 1'b1};
      end else begin
        rem_d  = trial[DEN_W-1:0];
        quot_d = {quot_q[Q_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign quot_o = quot_q;
  assign done_o = done_q;

endmodule

>>> src/hasu_ctrl.sv
`include "assert_macros.svh"

module hasu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_bin_i,
  input  logic              out_stall_i,
  input  hasu_pkg::status_t status_i,
  output hasu_pkg::cmd_t    cmd_o,
  output logic              in_stall_o,
  output logic              out_valid_o
);

  hasu_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      hasu_pkg::S_IDLE: begin
        if (in_valid_i && last_bin_i) begin
          state_d = hasu_pkg::S_START;
        end
      end
      hasu_pkg::S_START: begin
        state_d = status_i.empty ? hasu_pkg::S_OUT : hasu_pkg::S_MEAN_WAIT;
      end
      hasu_pkg::S_MEAN_WAIT: begin
        if (status_i.div_done) begin
          state_d = hasu_pkg::S_RD;
        end
      end
      hasu_pkg::S_RD:  state_d = hasu_pkg::S_CHK;
      hasu_pkg::S_CHK: state_d = status_i.hit ? hasu_pkg::S_MUL : hasu_pkg::S_RD;
      hasu_pkg::S_MUL: state_d = hasu_pkg::S_DIFF;
      hasu_pkg::S_DIFF: state_d = hasu_pkg::S_MED_START;
      hasu_pkg::S_MED_START: state_d = hasu_pkg::S_MED_WAIT;
      hasu_pkg::S_MED_WAIT: begin
        if (status_i.div_done) begin
          state_d = hasu_pkg::S_OUT;
        end
      end
      hasu_pkg::S_OUT: begin
        if (!out_stall_i) begin
          state_d = hasu_pkg::S_IDLE;
        end
      end
      default: state_d = hasu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      hasu_pkg::S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      hasu_pkg::S_START: begin
        if (status_i.empty) begin
          cmd_o.latch_empty = 1'b1;
          cmd_o.clear       = 1'b1;
        end else begin
          cmd_o.start_mean = 1'b1;
        end
      end
      hasu_pkg::S_MEAN_WAIT: cmd_o.take_mean = status_i.div_done;
      hasu_pkg::S_CHK:       cmd_o.walk_chk  = 1'b1;
      hasu_pkg::S_MUL:       cmd_o.do_mul    = 1'b1;
      hasu_pkg::S_DIFF:      cmd_o.do_diff   = 1'b1;
      hasu_pkg::S_MED_START: cmd_o.start_med = 1'b1;
      hasu_pkg::S_MED_WAIT: begin
        cmd_o.latch_out = status_i.div_done;
        cmd_o.clear     = status_i.div_done;
      end
      hasu_pkg::S_OUT: out_valid_o = 1'b1;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hasu_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `HASU_ASSERT(a_mean_to_walk, clk_i, rst_ni, (state_q == hasu_pkg::S_MEAN_WAIT && status_i.div_done) |=> (state_q == hasu_pkg::S_RD))
  `HASU_ASSERT(a_clear_to_out, clk_i, rst_ni, cmd_o.clear |=> (state_q == hasu_pkg::S_OUT))
  `HASU_ASSERT(a_out_holds, clk_i, rst_ni, (state_q == hasu_pkg::S_OUT && out_stall_i) |=> (state_q == hasu_pkg::S_OUT))

endmodule

>>> src/hasu_dpath.sv
module hasu_dpath #(
  parameter int unsigned BIN_DEPTH = 128,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hasu_pkg::cmd_t                cmd_i,
  input  logic [hasu_pkg::CountW-1:0]   male_count_i,
  input  logic [hasu_pkg::CountW-1:0]   female_count_i,
  output hasu_pkg::status_t             status_o,
  output logic [hasu_pkg::IdxOutW-1:0]  min_bin_o,
  output logic [hasu_pkg::IdxOutW-1:0]  max_bin_o,
  output logic [hasu_pkg::MeanOutW-1:0] mean_bin_o,
  output logic [hasu_pkg::MedOutW-1:0]  median_bin_o,
  output logic                          empty_set_o
);

  localparam int unsigned BinW   = hasu_pkg::BinW;
  localparam int unsigned IdxW   = $clog2(BIN_DEPTH);
  localparam int unsigned CntW   = $clog2(BIN_DEPTH + 1);
  localparam int unsigned TotW   = BinW + IdxW;
  localparam int unsigned WtW    = BinW + 2 * IdxW;
  localparam int unsigned DiffW  = TotW + 2;
  localparam int unsigned DenW   = TotW + 1;
  localparam int unsigned NumW   = ((WtW > DiffW) ? WtW : DiffW) + FRAC_BITS;
  localparam int unsigned ProdW  = IdxW + BinW;
  localparam int unsigned QW     = hasu_pkg::MedOutW;

  logic [CntW-1:0]  count_q;
  logic [TotW-1:0]  total_q;
  logic [WtW-1:0]   weight_q;
  logic [IdxW-1:0]  small_idx_q, large_idx_q;
  logic [BinW-1:0]  small_val_q, large_val_q;
  logic [IdxW-1:0]  walk_q;
  logic [TotW-1:0]  cum_q;
  logic [IdxW-1:0]  med_idx_q;
  logic [BinW-1:0]  med_bin_q;
  logic [ProdW-1:0] prod_q;
  logic [DiffW-1:0] mag_q;
  logic             neg_q;
  logic [hasu_pkg::MeanOutW-1:0] mean_q;
  logic [hasu_pkg::IdxOutW-1:0]  min_out_q, max_out_q;
  logic [hasu_pkg::MeanOutW-1:0] mean_out_q;
  logic [hasu_pkg::MedOutW-1:0]  med_out_q;
  logic                          empty_out_q;

  logic [BinW-1:0]  bin_sum;
  logic [IdxW-1:0]  wr_idx;
  logic             store_en;
  logic [BinW-1:0]  rd_data;
  logic [TotW-1:0]  cum_next;
  logic [DiffW-1:0] pos_val, neg_val;
  logic [NumW-1:0]  div_num;
  logic [DenW-1:0]  div_den;
  logic [QW-1:0]    quot;
  logic             div_done;

  assign bin_sum  = BinW'(male_count_i) + BinW'(female_count_i);
  assign wr_idx   = count_q[IdxW-1:0];
  assign store_en = cmd_i.accept && (count_q < CntW'(BIN_DEPTH));
  assign cum_next = cum_q + TotW'(rd_data);
  assign pos_val  = (DiffW'(prod_q) << 1) + DiffW'(total_q);
  assign neg_val  = DiffW'(cum_q) << 1;

  always_comb begin
    if (cmd_i.start_med) begin
      div_num = NumW'(mag_q) << FRAC_BITS;
      div_den = DenW'(med_bin_q) << 1;
    end else begin
      div_num = NumW'(weight_q) << FRAC_BITS;
      div_den = DenW'(total_q);
    end
  end

  hasu_ram #(
    .WIDTH(BinW),
    .DEPTH(BIN_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (store_en),
    .waddr_i(wr_idx),
    .wdata_i(bin_sum),
    .raddr_i(walk_q),
    .rdata_o(rd_data)
  );

  hasu_div #(
    .NUM_W(NumW),
    .DEN_W(DenW),
    .Q_W  (QW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.start_mean || cmd_i.start_med),
    .num_i  (div_num),
    .den_i  (div_den),
    .quot_o (quot),
    .done_o (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      total_q     <= '0;
      weight_q    <= '0;
      small_idx_q <= '0;
      large_idx_q <= '0;
      small_val_q <= '0;
      large_val_q <= '0;
    end else if (cmd_i.clear) begin
      count_q     <= '0;
      total_q     <= '0;
      weight_q    <= '0;
      small_idx_q <= '0;
      large_idx_q <= '0;
      small_val_q <= '0;
      large_val_q <= '0;
    end else if (store_en) begin
      count_q  <= count_q + 1'b1;
      total_q  <= total_q + TotW'(bin_sum);
      weight_q <= weight_q + WtW'(wr_idx) * WtW'(bin_sum);
      if (count_q == '0) begin
        small_val_q <= bin_sum;
        large_val_q <= bin_sum;
        small_idx_q <= '0;
        large_idx_q <= '0;
      end else begin
        if (bin_sum < small_val_q) begin
          small_val_q <= bin_sum;
          small_idx_q <= wr_idx;
        end
        if (bin_sum > large_val_q) begin
          large_val_q <= bin_sum;
          large_idx_q <= wr_idx;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_mean) begin
      walk_q <= '0;
      cum_q  <= '0;
    end else if (cmd_i.walk_chk) begin
      cum_q <= cum_next;
      if (status_o.hit) begin
        med_idx_q <= walk_q;
        med_bin_q <= rd_data;
      end else begin
        walk_q <= walk_q + 1'b1;
      end
    end
    if (cmd_i.take_mean) begin
      mean_q <= quot[hasu_pkg::MeanOutW-1:0];
    end
    if (cmd_i.do_mul) begin
      prod_q <= ProdW'(med_idx_q) * ProdW'(med_bin_q);
    end
    if (cmd_i.do_diff) begin
      if (pos_val >= neg_val) begin
        mag_q <= pos_val - neg_val;
        neg_q <= 1'b0;
      end else begin
        mag_q <= neg_val - pos_val;
        neg_q <= 1'b1;
      end
    end
    if (cmd_i.latch_empty) begin
      min_out_q   <= '0;
      max_out_q   <= '0;
      mean_out_q  <= '0;
      med_out_q   <= '0;
      empty_out_q <= 1'b1;
    end else if (cmd_i.latch_out) begin
      min_out_q   <= hasu_pkg::IdxOutW'(small_idx_q);
      max_out_q   <= hasu_pkg::IdxOutW'(large_idx_q);
      mean_out_q  <= mean_q;
      med_out_q   <= neg_q ? QW'(QW'(0) - quot) : quot;
      empty_out_q <= 1'b0;
    end
  end

  assign status_o.empty    = (total_q == '0);
  assign status_o.hit      = ({cum_next, 1'b0} >= {1'b0, total_q}) ||
                             ((CntW'(walk_q) + 1'b1) == count_q);
  assign status_o.div_done = div_done;

  assign min_bin_o    = min_out_q;
  assign max_bin_o    = max_out_q;
  assign mean_bin_o   = mean_out_q;
  assign median_bin_o = med_out_q;
  assign empty_set_o  = empty_out_q;

endmodule

>>> src/histogram_age_statistics_unit.sv
// Age histogram statistics. Each input transaction carries one age bin as a
// male and a female count, starting from bin 0; the transaction marked last
// ends the set and yields one output transaction with the first smallest and
// first largest bin, the weighted mean bin and the interpolated median bin
// (FRAC_BITS fractional bits, truncated), or the empty flag with zeros when
// the total is zero. Bins are taken one per cycle while the unit is idle.
// After the last bin the input stays stalled until the output transaction
// has been taken. The mean and the median are computed by the shared
// bit-serial divider, one quotient bit per cycle, whose dividend width NumW
// is 55 bits at the default parameters; the median search reads the bin
// store one entry at a time, in a read state and then a check state. An
// empty set skips the divider and goes straight to the output.
// Bins beyond BIN_DEPTH are ignored.
module histogram_age_statistics_unit #(
  parameter int unsigned BIN_DEPTH = 128,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [hasu_pkg::CountW-1:0]   male_count_i,
  input  logic [hasu_pkg::CountW-1:0]   female_count_i,
  input  logic                          last_bin_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [hasu_pkg::IdxOutW-1:0]  min_bin_o,
  output logic [hasu_pkg::IdxOutW-1:0]  max_bin_o,
  output logic [hasu_pkg::MeanOutW-1:0] mean_bin_o,
  output logic [hasu_pkg::MedOutW-1:0]  median_bin_o,
  output logic                          empty_set_o
);

  hasu_pkg::cmd_t    cmd;
  hasu_pkg::status_t status;

  hasu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_bin_i (last_bin_i),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o)
  );

  hasu_dpath #(
    .BIN_DEPTH(BIN_DEPTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .male_count_i  (male_count_i),
    .female_count_i(female_count_i),
    .status_o      (status),
    .min_bin_o     (min_bin_o),
    .max_bin_o     (max_bin_o),
    .mean_bin_o    (mean_bin_o),
    .median_bin_o  (median_bin_o),
    .empty_set_o   (empty_set_o)
  );

endmodule

>>> tb/sv/tb_histogram_age_statistics_unit.sv
`timescale 1ns / 100ps

module tb_histogram_age_statistics_unit;

  localparam int unsigned NumBins  = 128;
  localparam int unsigned FracW    = 8;
  localparam int unsigned Drain    = 500;
  localparam longint unsigned CycleLimit = 1_000_000;

  typedef struct packed {
    logic [hasu_pkg::IdxOutW-1:0]  min_bin;
    logic [hasu_pkg::IdxOutW-1:0]  max_bin;
    logic [hasu_pkg::MeanOutW-1:0] mean_bin;
    logic [hasu_pkg::MedOutW-1:0]  median_bin;
    logic                          empty_set;
  } stats_t;

  typedef struct {
    logic [hasu_pkg::CountW-1:0] male;
    logic [hasu_pkg::CountW-1:0] female;
    logic                        last;
    logic                        typed;
    stats_t                      stats;
  } bin_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [hasu_pkg::CountW-1:0] male_count_i = '0;
  logic [hasu_pkg::CountW-1:0] female_count_i = '0;
  logic last_bin_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [hasu_pkg::IdxOutW-1:0] min_bin_o;
  logic [hasu_pkg::IdxOutW-1:0] max_bin_o;
  logic [hasu_pkg::MeanOutW-1:0] mean_bin_o;
  logic [hasu_pkg::MedOutW-1:0] median_bin_o;
  logic empty_set_o;

  stats_t expected_stats[$];
  bin_row_t age_rows[$];
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors = 0;
  longint unsigned cycles = 0;

  longint unsigned set_bins[NumBins];
  int unsigned set_len = 0;
  longint unsigned set_total = 0;
  longint unsigned set_weighted = 0;
  int unsigned low_idx = 0;
  longint unsigned low_val = 0;
  int unsigned high_idx = 0;
  longint unsigned high_val = 0;

  histogram_age_statistics_unit u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .male_count_i(male_count_i),
    .female_count_i(female_count_i),
    .last_bin_i(last_bin_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .min_bin_o(min_bin_o),
    .max_bin_o(max_bin_o),
    .mean_bin_o(mean_bin_o),
    .median_bin_o(median_bin_o),
    .empty_set_o(empty_set_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void absorb_bin(logic [hasu_pkg::CountW-1:0] male,
                                     logic [hasu_pkg::CountW-1:0] female);
    longint unsigned c;
    c = longint'(male) + longint'(female);
    if (set_len < NumBins) begin
      set_bins[set_len] = c;
      if (set_len == 0) begin
        low_val = c;
        high_val = c;
        low_idx = 0;
        high_idx = 0;
      end else begin
        if (c < low_val) begin
          low_val = c;
          low_idx = set_len;
        end
        if (c > high_val) begin
          high_val = c;
          high_idx = set_len;
        end
      end
      set_total += c;
      set_weighted += longint'(set_len) * c;
      set_len++;
    end
  endfunction

  function automatic stats_t close_set();
    stats_t s;
    longint unsigned q, r, cum, b, pos, neg, med;
    int unsigned m;
    s = '0;
    if (set_total == 0) begin
      s.empty_set = 1'b1;
    end else begin
      s.min_bin = low_idx[hasu_pkg::IdxOutW-1:0];
      s.max_bin = high_idx[hasu_pkg::IdxOutW-1:0];
      q = set_weighted / set_total;
      r = set_weighted % set_total;
      s.mean_bin = hasu_pkg::MeanOutW'((q << FracW) + ((r << FracW) / set_total));
      cum = 0;
      m = 0;
      for (int unsigned i = 0; i < set_len; i++) begin
        cum += set_bins[i];
        m = i;
        if (2 * cum >= set_total) break;
      end
      b = set_bins[m];
      pos = 2 * longint'(m) * b + set_total;
      neg = 2 * cum;
      if (pos >= neg) med = ((pos - neg) << FracW) / (2 * b);
      else med = 0 - (((neg - pos) << FracW) / (2 * b));
      s.median_bin = med[hasu_pkg::MedOutW-1:0];
    end
    set_len = 0;
    set_total = 0;
    set_weighted = 0;
    low_idx = 0;
    low_val = 0;
    high_idx = 0;
    high_val = 0;
    return s;
  endfunction

  task automatic add_row(logic [hasu_pkg::CountW-1:0] male,
                         logic [hasu_pkg::CountW-1:0] female,
                         logic last, logic typed, stats_t stats);
    bin_row_t r;
    r.male = male;
    r.female = female;
    r.last = last;
    r.typed = typed;
    r.stats = stats;
    age_rows.insert(age_rows.size(), r);
  endtask

  task automatic send_bin(bin_row_t row);
    stats_t s;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    male_count_i <= row.male;
    female_count_i <= row.female;
    last_bin_i <= row.last;
    do @(posedge clk_i); while (in_stall_o);
    absorb_bin(row.male, row.female);
    if (row.last) begin
      s = close_set();
      expected_stats.insert(expected_stats.size(), row.typed ? row.stats : s);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [hasu_pkg::CountW-1:0] pick_count();
    case ($urandom_range(3))
      0: return '0;
      1: return $urandom;
      2: return $urandom_range(1000);
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  always @(posedge clk_i) begin
    stats_t got, want;
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{min_bin_o, max_bin_o, mean_bin_o, median_bin_o, empty_set_o};
      if (expected_stats.size() == 0) begin
        $display("%0t: unexpected transaction, actual %h", $time, got);
        errors++;
      end else begin
        want = expected_stats.pop_front();
        if (got.min_bin !== want.min_bin)
          $display("%0t: min_bin expected %0d actual %0d", $time, want.min_bin, got.min_bin);
        if (got.max_bin !== want.max_bin)
          $display("%0t: max_bin expected %0d actual %0d", $time, want.max_bin, got.max_bin);
        if (got.mean_bin !== want.mean_bin)
          $display("%0t: mean_bin expected %h actual %h", $time, want.mean_bin,
                   got.mean_bin);
        if (got.median_bin !== want.median_bin)
          $display("%0t: median_bin expected %h actual %h", $time, want.median_bin,
                   got.median_bin);
        if (got.empty_set !== want.empty_set)
          $display("%0t: empty_set expected %b actual %b", $time, want.empty_set,
                   got.empty_set);
        if (got !== want) errors++;
      end
    end
  end

  initial begin
    bin_row_t row;
    int unsigned sent, len;
    stats_t empty_stats, one_bin_stats;
    empty_stats = '{0, 0, 0, 0, 1'b1};
    one_bin_stats = '{0, 0, 0, 16'hFF80, 1'b0};

    add_row(32'd0, 32'd0, 1'b1, 1'b1, empty_stats);
    add_row(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, one_bin_stats);
    add_row(32'd0, 32'd0, 1'b0, 1'b0, '0);
    add_row(32'd0, 32'd0, 1'b0, 1'b0, '0);
    add_row(32'd0, 32'd0, 1'b1, 1'b1, empty_stats);
    add_row(32'hFFFFFFFF, 32'd0, 1'b0, 1'b0, '0);
    add_row(32'd0, 32'hFFFFFFFF, 1'b0, 1'b0, '0);
    add_row(32'd1, 32'd0, 1'b0, 1'b0, '0);
    add_row(32'd0, 32'd0, 1'b0, 1'b0, '0);
    add_row(32'd5, 32'd5, 1'b1, 1'b0, '0);
    add_row(32'd1, 32'd2, 1'b0, 1'b0, '0);
    add_row(32'd10, 32'd20, 1'b0, 1'b0, '0);
    add_row(32'd100, 32'd0, 1'b0, 1'b0, '0);
    add_row(32'd3, 32'd3, 1'b0, 1'b0, '0);
    add_row(32'd7, 32'd0, 1'b1, 1'b0, '0);
    add_row(32'd4, 32'd4, 1'b0, 1'b0, '0);
    add_row(32'd8, 32'd0, 1'b0, 1'b0, '0);
    add_row(32'd0, 32'd8, 1'b0, 1'b0, '0);
    add_row(32'd2, 32'd2, 1'b1, 1'b0, '0);
    add_row(32'd0, 32'd1, 1'b0, 1'b0, '0);
    add_row(32'd1, 32'd0, 1'b1, 1'b0, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_gap_pct = 16;
    recv_stall_pct = 58;
    foreach (age_rows[i]) send_bin(age_rows[i]);
    wait_drained();

    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      send_gap_pct = (phase == 0) ? 16 : (phase == 1) ? 58 : 0;
      recv_stall_pct = (phase == 0) ? 58 : (phase == 1) ? 16 : 0;
      while (sent < 480 * (phase + 1)) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(NumBins + 8, NumBins - 2)
                                         : $urandom_range(20, 1);
        for (int unsigned k = 0; k < len; k++) begin
          row.male = pick_count();
          row.female = pick_count();
          row.last = (k == len - 1);
          row.typed = 1'b0;
          row.stats = '0;
          send_bin(row);
          sent++;
        end
      end
      wait_drained();
    end

    wait_drained();
    repeat (Drain) @(posedge clk_i);
    if (errors == 0 && expected_stats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
